FILE: rtl/core/tcwq_pkg.sv
// Shared types, constants and helpers of the two-class weighted queue.
package tcwq_pkg;

  // Queue geometry.
  localparam int QUEUE_DEPTH = 16;
  localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int VALUE_W     = 32;
  localparam int WEIGHT_W    = 4;

  localparam logic [WEIGHT_W-1:0]       WEIGHT_RESET = 4'd3;
  localparam logic signed [VALUE_W-1:0] NONE_VALUE   = -32'sd1;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [OCC_W-1:0]  occ_t;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_ENQ      = 2'd0,
    CMD_PLAIN    = 2'd1,
    CMD_WEIGHTED = 2'd2
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Input word.
  typedef struct packed {
    logic [1:0]                command;
    logic signed [VALUE_W-1:0] item_value;
    logic                      item_class;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic signed [VALUE_W-1:0] served_value;
    status_t                   status;
  } out_word_t;

  // Requests from the sequencer to the slot store.
  typedef struct packed {
    logic                      rd_en;
    slot_t                     rd_addr;
    logic                      dat_we;
    slot_t                     dat_addr;
    logic signed [VALUE_W-1:0] dat_value;
    logic                      dat_cls;
    logic                      link_we;
    slot_t                     link_addr;
    slot_t                     link_data;
  } store_req_t;

  // Registered read data of the slot store.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      cls;
    slot_t                     link;
  } store_rd_t;

  // Link of a slot that was never written: the free chain runs slot by slot
  // and wraps from the last slot to slot zero.
  function automatic slot_t reset_link(input slot_t s);
    slot_t r;
    if (s == SLOT_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/tcwq_slot_store.sv
// Slot store: entry values, class bits and chain links with one read port.
module tcwq_slot_store (
  input  logic                clk,
  input  logic                rst_n,
  input  tcwq_pkg::store_req_t req,
  output tcwq_pkg::store_rd_t  rd
);
  import tcwq_pkg::*;

  logic signed [VALUE_W-1:0] value_mem [QUEUE_DEPTH];
  logic                      cls_mem   [QUEUE_DEPTH];
  slot_t                     link_mem  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]    link_vld_r;
  store_rd_t                 rd_r;

  // Value and class memory: written on enqueue, read with the link.
  always_ff @(posedge clk) begin
    if (req.dat_we) begin
      value_mem[req.dat_addr] <= req.dat_value;
      cls_mem[req.dat_addr]   <= req.dat_cls;
    end
  end

  // Link memory; a slot whose link was never written reads its free-chain link.
  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_addr] <= req.link_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_vld_r <= '0;
    end else if (req.link_we) begin
      link_vld_r[req.link_addr] <= 1'b1;
    end
  end

  // Registered read port, held while no read is issued.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_r.value <= value_mem[req.rd_addr];
      rd_r.cls   <= cls_mem[req.rd_addr];
      rd_r.link  <= link_vld_r[req.rd_addr] ? link_mem[req.rd_addr]
                                            : reset_link(req.rd_addr);
    end
  end

  assign rd = rd_r;

endmodule

FILE: rtl/core/tcwq_ctrl.sv
// Sequencer: queue pointers, serve counter and the chain walk with its class compare.
module tcwq_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  tcwq_pkg::in_word_t           in_word,
  input  logic [tcwq_pkg::WEIGHT_W-1:0] weight,
  input  tcwq_pkg::store_rd_t          rd,
  output tcwq_pkg::store_req_t         req,
  output logic                         busy,
  output logic                         out_valid,
  output tcwq_pkg::out_word_t          out_word
);
  import tcwq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_ALLOC,
    S_ENQ_APPEND,
    S_SCAN,
    S_FIX_PREV,
    S_RELEASE
  } state_t;

  state_t                    state_r,    state_nxt;
  slot_t                     head_r,     head_nxt;
  slot_t                     tail_r,     tail_nxt;
  slot_t                     free_r,     free_nxt;
  occ_t                      occ_r,      occ_nxt;
  logic [WEIGHT_W-1:0]       cnt_r,      cnt_nxt;
  slot_t                     cur_r,      cur_nxt;
  slot_t                     prev_r,     prev_nxt;
  logic                      has_prev_r, has_prev_nxt;
  slot_t                     next_r,     next_nxt;
  logic signed [VALUE_W-1:0] val_r,      val_nxt;
  logic                      cls_r,      cls_nxt;
  occ_t                      n_r,        n_nxt;
  logic                      plain_r,    plain_nxt;
  logic                      want_r,     want_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_word_t                 out_word_r,  out_word_nxt;

  logic want_low_now;
  logic hit;

  assign want_low_now = (cnt_r < weight);
  // The shared compare: does the entry under the walk carry the wanted class?
  assign hit          = plain_r || (rd.cls == want_r);

  // Next-state and store request logic.
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    free_nxt      = free_r;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    has_prev_nxt  = has_prev_r;
    next_nxt      = next_r;
    val_nxt       = val_r;
    cls_nxt       = cls_r;
    n_nxt         = n_r;
    plain_nxt     = plain_r;
    want_nxt      = want_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    req           = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_word.command)
            CMD_ENQ: begin
              if (occ_r == OCC_W'(QUEUE_DEPTH)) begin
                out_valid_nxt             = 1'b1;
                out_word_nxt.served_value = NONE_VALUE;
                out_word_nxt.status       = ST_FULL;
              end else begin
                cur_nxt      = free_r;
                val_nxt      = in_word.item_value;
                cls_nxt      = in_word.item_class;
                req.rd_en    = 1'b1;
                req.rd_addr  = free_r;
                state_nxt    = S_ENQ_ALLOC;
              end
            end
            CMD_PLAIN, CMD_WEIGHTED: begin
              if (occ_r == '0) begin
                out_valid_nxt             = 1'b1;
                out_word_nxt.served_value = NONE_VALUE;
                out_word_nxt.status       = ST_EMPTY;
              end else begin
                plain_nxt    = (in_word.command == CMD_PLAIN);
                want_nxt     = !want_low_now;
                cur_nxt      = head_r;
                has_prev_nxt = 1'b0;
                n_nxt        = '0;
                req.rd_en    = 1'b1;
                req.rd_addr  = head_r;
                state_nxt    = S_SCAN;
              end
            end
            default: begin
              out_valid_nxt             = 1'b1;
              out_word_nxt.served_value = NONE_VALUE;
              out_word_nxt.status       = ST_OK;
            end
          endcase
        end
      end

      // Take the free head slot and fill it; it becomes the chain end.
      S_ENQ_ALLOC: begin
        free_nxt      = rd.link;
        req.dat_we    = 1'b1;
        req.dat_addr  = cur_r;
        req.dat_value = val_r;
        req.dat_cls   = cls_r;
        req.link_we   = 1'b1;
        req.link_addr = cur_r;
        req.link_data = '0;
        state_nxt     = S_ENQ_APPEND;
      end

      // Hook the new slot behind the tail.
      S_ENQ_APPEND: begin
        if (occ_r != '0) begin
          req.link_we   = 1'b1;
          req.link_addr = tail_r;
          req.link_data = cur_r;
        end else begin
          head_nxt = cur_r;
        end
        tail_nxt                  = cur_r;
        occ_nxt                   = occ_r + OCC_W'(1);
        out_valid_nxt             = 1'b1;
        out_word_nxt.served_value = NONE_VALUE;
        out_word_nxt.status       = ST_OK;
        state_nxt                 = S_IDLE;
      end

      // Walk the chain one entry a cycle until the wanted class shows up or every entry is checked.
      S_SCAN: begin
        if (hit) begin
          val_nxt   = rd.value;
          next_nxt  = rd.link;
          state_nxt = S_FIX_PREV;
        end else if ((n_r + OCC_W'(1)) == occ_r) begin
          cnt_nxt                   = want_r ? '0 : weight;
          out_valid_nxt             = 1'b1;
          out_word_nxt.served_value = NONE_VALUE;
          out_word_nxt.status       = ST_ABSENT;
          state_nxt                 = S_IDLE;
        end else begin
          prev_nxt     = cur_r;
          has_prev_nxt = 1'b1;
          cur_nxt      = rd.link;
          n_nxt        = n_r + OCC_W'(1);
          req.rd_en    = 1'b1;
          req.rd_addr  = rd.link;
        end
      end

      // Bridge the chain over the served slot.
      S_FIX_PREV: begin
        if (has_prev_r) begin
          req.link_we   = 1'b1;
          req.link_addr = prev_r;
          req.link_data = next_r;
        end else begin
          head_nxt = next_r;
        end
        state_nxt = S_RELEASE;
      end

      // Return the slot to the free chain and report the served word.
      S_RELEASE: begin
        req.link_we   = 1'b1;
        req.link_addr = cur_r;
        req.link_data = free_r;
        free_nxt      = cur_r;
        if (cur_r == tail_r) begin
          tail_nxt = has_prev_r ? prev_r : '0;
        end
        occ_nxt = occ_r - OCC_W'(1);
        if (!plain_r) begin
          cnt_nxt = want_r ? '0 : (cnt_r + WEIGHT_W'(1));
        end
        out_valid_nxt             = 1'b1;
        out_word_nxt.served_value = val_r;
        out_word_nxt.status       = ST_OK;
        state_nxt                 = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, pointers and the registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      free_r      <= '0;
      occ_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_r      <= free_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    has_prev_r <= has_prev_nxt;
    next_r     <= next_nxt;
    val_r      <= val_nxt;
    cls_r      <= cls_nxt;
    n_r        <= n_nxt;
    plain_r    <= plain_nxt;
    want_r     <= want_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // A result is only shown once the sequencer is back at rest.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while the sequencer is busy");

  // An enqueue into a full store is flagged on the next cycle.
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_word.command == CMD_ENQ) && (occ_r == OCC_W'(QUEUE_DEPTH)))
    |=> (out_valid_r && (out_word_r.status == ST_FULL)))
    else $error("full enqueue not flagged");

  // The walk never passes the number of stored entries.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ((n_r < occ_r) && (occ_r != '0)))
    else $error("chain walk ran past the stored entries");

  // Releasing a slot takes exactly one entry away.
  a_release_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RELEASE) |=> (occ_r == ($past(occ_r) - OCC_W'(1))))
    else $error("occupancy not decremented on release");

  // Occupancy stays within the store.
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENQ_APPEND) |-> (occ_r < OCC_W'(QUEUE_DEPTH)))
    else $error("append into a full store");

endmodule

FILE: rtl/core/two_class_weighted_queue.sv
// Top level of the two-class weighted queue: weight register, sequencer and slot store.
//
// Usage. An item word (command, value, class) is taken at a rising edge where start is
// high and busy is low. Every item gives exactly one result word on out_word, marked by
// out_valid for one cycle; the receiver has no way to hold it off.
// Commands: enqueue appends a value with its class, plain dequeue serves the oldest
// entry, weighted dequeue serves the oldest low-class entry while the serve counter is
// below the weight, and otherwise the oldest high-class entry.
// Sequence: a dropped enqueue, an empty dequeue and an unused command answer in the cycle
// after acceptance with busy staying low. An enqueue passes an allocate and an append
// state; a dequeue walks the chain, then bridges it over the served slot and releases
// the slot. The chain walk reads one slot a cycle through the single read port of the
// slot store, and stops at the wanted class or after the last stored entry.
// A new item can be taken in the same cycle that a result is shown.
// Configuration: cfg_data writes the low-serves-per-high weight whenever cfg_valid and
// cfg_ready are high; cfg_ready is high while the block is idle.
// Reset: clears the queue to empty, the serve counter to zero and the weight to three.
// No clearing pass is needed, so items are taken right after reset.
module two_class_weighted_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  tcwq_pkg::in_word_t            in_word,
  output logic                          out_valid,
  output tcwq_pkg::out_word_t           out_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcwq_pkg::WEIGHT_W-1:0] cfg_data
);
  import tcwq_pkg::*;

  logic [WEIGHT_W-1:0] weight_r;
  store_req_t          req;
  store_rd_t           rd;

  // Weight register, writable while the sequencer rests.
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      weight_r <= cfg_data;
    end
  end

  tcwq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_word   (in_word),
    .weight    (weight_r),
    .rd        (rd),
    .req       (req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  tcwq_slot_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rd    (rd)
  );

endmodule
